>>> design/cfe_pkg.sv
`timescale 1ns / 1ps

package cfe_pkg;

  // fixed point one and exp2 polynomial coefficients
  localparam int unsigned ONE_Q  = 65536;
  localparam logic [15:0] EXP_C1 = 16'd43030;
  localparam logic [14:0] EXP_C2 = 15'd22506;

  // reset value of every register pair: 1.0 in both halves
  localparam logic [63:0] PAIR_RESET = 64'h0001_0000_0001_0000;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_EMAX      = 3'd0,
    REG_POTENCY   = 3'd1,
    REG_HILL      = 3'd2,
    REG_GAIN      = 3'd3,
    REG_IPOTENCY  = 3'd4,
    REG_IHILL     = 3'd5,
    REG_MODE      = 3'd6
  } reg_idx_e;

  // lane 0 is drug a (or b on a), lane 1 is drug b (or a on b)
  typedef struct packed {
    logic [1:0][31:0] emax;
    logic [1:0][31:0] potency;
    logic [1:0][31:0] hill;
    logic [1:0][31:0] gain;
    logic [1:0][31:0] ipotency;
    logic [1:0][31:0] ihill;
    logic             pot_mode;
  } cfg_t;

  // per item data that rides along the second hill stage
  typedef struct packed {
    logic [1:0][47:0] t;
    logic [1:0]       flag;
  } eside_t;

endpackage

>>> design/cfe_if.sv
`timescale 1ns / 1ps

// concentration channel
interface cfe_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] conc_a;
  logic [31:0] conc_b;

  modport source (output valid, conc_a, conc_b, input ready);
  modport sink   (input valid, conc_a, conc_b, output ready);
endinterface

// combined effect channel
interface cfe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] effect;
  logic        saturated;

  modport source (output valid, effect, saturated, input ready);
  modport sink   (input valid, effect, saturated, output ready);
endinterface

>>> design/cfe_hill.sv
`timescale 1ns / 1ps

// two lane hill fraction 1 / (1 + (k/c)^m), fully pipelined
// the user must hold m_i static while items are in flight; the block does not enforce it
module cfe_hill import cfe_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [1:0][31:0]        k_i,
  input  logic [1:0][31:0]        c_i,
  input  logic [1:0][31:0]        m_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    vld_o,
  output logic [1:0][16:0]        f_o,
  output logic [SIDE_W-1:0]       side_o
);

  localparam int LOG_N = 16;
  localparam int DIV_N = 17;
  localparam int LAT   = LOG_N + DIV_N + 8;

  typedef enum logic [1:0] {HC_NORM, HC_HALF, HC_ZERO, HC_ONE} hcode_e;
  typedef enum logic [1:0] {EX_NORM, EX_BIG, EX_ZERO} ex_e;

  function automatic logic [4:0] lead_one(input logic [31:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  // one squaring of the q1.31 mantissa, msb is the next fraction bit
  function automatic logic [32:0] sq_step(input logic [31:0] m);
    logic [63:0] p;
    logic [32:0] s;
    p = m * m;
    s = p[63:31];
    if (s[32]) return {1'b1, s[32:1]};
    return {1'b0, s[31:0]};
  endfunction

  logic [LAT-1:0]             vld_q;
  logic [LAT-1:0][SIDE_W-1:0] side_q;

  // valid and side data travel with the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[LAT-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) side_q <= {side_q[LAT-2:0], side_i};
  end

  assign vld_o  = vld_q[LAT-1];
  assign side_o = side_q[LAT-1];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    hcode_e      code_q [LAT-1];
    hcode_e      code_d;
    logic [4:0]  pk_d, pc_d;
    logic [31:0] mk_q [LOG_N+1];
    logic [31:0] mc_q [LOG_N+1];
    logic [15:0] frk_q [LOG_N+1];
    logic [15:0] frc_q [LOG_N+1];
    logic [4:0]  pk_q [LOG_N+1];
    logic [4:0]  pc_q [LOG_N+1];
    logic signed [22:0] d_w;
    logic [20:0] dabs_q;
    logic        dneg_q;
    logic [52:0] mprod_w;
    logic [36:0] mag_q;
    logic        mneg_q;
    logic [21:0] u_w;
    ex_e         ex_p_q, ex_t_q, ex_m_q;
    logic [5:0]  kk_p_q, kk_t_q, kk_m_q;
    logic [15:0] f_p_q;
    logic [31:0] c1_w;
    logic [15:0] t1_q;
    logic [31:0] ff_q;
    logic [46:0] c2_w;
    logic [16:0] mant_q;
    logic [47:0] r_w;
    logic [47:0] dd_q;
    logic [32:0] rem_q [DIV_N];
    logic [16:0] q_q [DIV_N];
    logic [47:0] dv_q [DIV_N];
    logic [16:0] f_q;

    // special cases and normalization
    always_comb begin
      pk_d = lead_one(k_i[l]);
      pc_d = lead_one(c_i[l]);
      if (m_i[l] == '0)      code_d = HC_HALF;
      else if (c_i[l] == '0) code_d = HC_ZERO;
      else if (k_i[l] == '0) code_d = HC_ONE;
      else                   code_d = HC_NORM;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        code_q[0] <= code_d;
        for (int i = 1; i < LAT - 1; i++) code_q[i] <= code_q[i-1];
        mk_q[0]  <= k_i[l] << (5'd31 - pk_d);
        mc_q[0]  <= c_i[l] << (5'd31 - pc_d);
        pk_q[0]  <= pk_d;
        pc_q[0]  <= pc_d;
        frk_q[0] <= '0;
        frc_q[0] <= '0;
      end
    end

    // log2 fraction, one bit per stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int i = 1; i <= LOG_N; i++) begin
          logic [32:0] sk, sc;
          sk = sq_step(mk_q[i-1]);
          sc = sq_step(mc_q[i-1]);
          mk_q[i]  <= sk[31:0];
          mc_q[i]  <= sc[31:0];
          frk_q[i] <= {frk_q[i-1][14:0], sk[32]};
          frc_q[i] <= {frc_q[i-1][14:0], sc[32]};
          pk_q[i]  <= pk_q[i-1];
          pc_q[i]  <= pc_q[i-1];
        end
      end
    end

    // log2 k - log2 c as sign and magnitude
    assign d_w = $signed({1'b0, pk_q[LOG_N], frk_q[LOG_N]})
               - $signed({1'b0, pc_q[LOG_N], frc_q[LOG_N]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dneg_q <= d_w[22];
        dabs_q <= d_w[22] ? 21'(-d_w) : d_w[20:0];
      end
    end

    // scale by the exponent
    assign mprod_w = dabs_q * m_i[l];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mag_q  <= mprod_w[52:16];
        mneg_q <= dneg_q;
      end
    end

    // exp2 range check and split into integer and fraction
    assign u_w = mneg_q ? (22'(16 * ONE_Q) - {1'b0, mag_q[20:0]})
                        : ({1'b0, mag_q[20:0]} + 22'(16 * ONE_Q));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!mneg_q && mag_q >= 37'(31 * ONE_Q))    ex_p_q <= EX_BIG;
        else if (mneg_q && mag_q > 37'(16 * ONE_Q)) ex_p_q <= EX_ZERO;
        else                                         ex_p_q <= EX_NORM;
        kk_p_q <= u_w[21:16];
        f_p_q  <= u_w[15:0];
      end
    end

    // polynomial terms
    assign c1_w = EXP_C1 * f_p_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ex_t_q <= ex_p_q;
        kk_t_q <= kk_p_q;
        t1_q   <= c1_w[31:16];
        ff_q   <= f_p_q * f_p_q;
      end
    end

    assign c2_w = EXP_C2 * ff_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ex_m_q <= ex_t_q;
        kk_m_q <= kk_t_q;
        mant_q <= 17'(ONE_Q) + 17'(t1_q) + 17'(c2_w[46:32]);
      end
    end

    // shift by the integer part, form the divisor
    always_comb begin
      case (ex_m_q)
        EX_BIG:  r_w = 48'h8000_0000_0000;
        EX_ZERO: r_w = '0;
        default: begin
          if (kk_m_q >= 6'd16) r_w = 48'(mant_q) << (kk_m_q - 6'd16);
          else                 r_w = 48'(mant_q) >> (6'd16 - kk_m_q);
        end
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (en_i) dd_q <= 48'(ONE_Q) + r_w;
    end

    // restoring division of 2^32, one quotient bit per stage
    for (genvar j = 0; j < DIV_N; j++) begin : g_div
      logic [32:0] rem_in;
      logic [16:0] q_in;
      logic [47:0] d_in;
      logic [64:0] trial;
      if (j == 0) begin : g_first
        assign rem_in = 33'h1_0000_0000;
        assign q_in   = '0;
        assign d_in   = dd_q;
      end else begin : g_next
        assign rem_in = rem_q[j-1];
        assign q_in   = q_q[j-1];
        assign d_in   = dv_q[j-1];
      end
      assign trial = {17'd0, d_in} << (DIV_N - 1 - j);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          dv_q[j] <= d_in;
          if ({32'd0, rem_in} >= trial) begin
            rem_q[j] <= rem_in - trial[32:0];
            q_q[j]   <= q_in | (17'd1 << (DIV_N - 1 - j));
          end else begin
            rem_q[j] <= rem_in;
            q_q[j]   <= q_in;
          end
        end
      end
    end

    // apply special cases
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        case (code_q[LAT-2])
          HC_HALF: f_q <= 17'(ONE_Q / 2);
          HC_ZERO: f_q <= '0;
          HC_ONE:  f_q <= 17'(ONE_Q);
          default: f_q <= q_q[DIV_N-1];
        endcase
      end
    end

    assign f_o[l] = f_q;
  end

endmodule

>>> design/cfe_factor.sv
`timescale 1ns / 1ps

// interaction factor g, scaled potency and scaled emax per lane
module cfe_factor import cfe_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [1:0][16:0] h_i,
  input  logic [1:0][31:0] c_i,
  input  cfg_t             cfg_i,
  output logic             vld_o,
  output logic [1:0][31:0] k_o,
  output logic [1:0][31:0] c_o,
  output eside_t           side_o
);

  localparam int     PW   = 33 + VALUE_WIDTH;
  localparam int     KW   = PW - 16;
  localparam longint VMAX = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;

  logic [3:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  assign vld_o = vld_q[3];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [31:0]              c_q [4];
    logic signed [49:0]       gh_q;
    logic signed [34:0]       s_w;
    logic signed [VALUE_WIDTH-1:0] g_q;
    logic                     flg2_q, flg3_q, flg4_q;
    logic signed [PW-1:0]     pk_q, pt_q;
    logic signed [KW-1:0]     kp_w;
    logic [31:0]              k2_q;
    logic [47:0]              t_q;

    // gain times interaction fraction
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        gh_q   <= $signed(cfg_i.gain[l]) * $signed({1'b0, h_i[l]});
        c_q[0] <= c_i[l];
        for (int i = 1; i < 4; i++) c_q[i] <= c_q[i-1];
      end
    end

    // g = 1 + gain * h, clipped
    assign s_w = 35'(gh_q >>> 16) + 35'sd65536;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (s_w > 35'(VMAX)) begin
          g_q    <= VALUE_WIDTH'(VMAX);
          flg2_q <= 1'b1;
        end else if (s_w < 35'(VMIN)) begin
          g_q    <= VALUE_WIDTH'(VMIN);
          flg2_q <= 1'b1;
        end else begin
          g_q    <= VALUE_WIDTH'(s_w);
          flg2_q <= 1'b0;
        end
      end
    end

    // potency and emax scaled by g
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pk_q   <= $signed({1'b0, cfg_i.potency[l]}) * g_q;
        pt_q   <= $signed({1'b0, cfg_i.emax[l]}) * g_q;
        flg3_q <= flg2_q;
      end
    end

    assign kp_w = KW'(pk_q >>> 16);

    // clip scaled potency to the unsigned range, pick by mode
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        t_q <= 48'(pt_q >>> 16);
        if (!cfg_i.pot_mode) begin
          k2_q   <= cfg_i.potency[l];
          flg4_q <= flg3_q;
        end else if (kp_w < 0) begin
          k2_q   <= '0;
          flg4_q <= 1'b1;
        end else if (kp_w > $signed(KW'(33'h0_FFFF_FFFF))) begin
          k2_q   <= '1;
          flg4_q <= 1'b1;
        end else begin
          k2_q   <= kp_w[31:0];
          flg4_q <= flg3_q;
        end
      end
    end

    assign k_o[l]         = k2_q;
    assign c_o[l]         = c_q[3];
    assign side_o.t[l]    = t_q;
    assign side_o.flag[l] = flg4_q;
  end

endmodule

>>> design/cfe_merge.sv
`timescale 1ns / 1ps

// single drug effects and bliss combination
module cfe_merge import cfe_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [1:0][16:0] f_i,
  input  eside_t           side_i,
  input  cfg_t             cfg_i,
  output logic             vld_o,
  output logic [31:0]      effect_o,
  output logic             sat_o
);

  localparam int     WR   = 2 * VALUE_WIDTH + 1;
  localparam longint VMAX = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;

  logic [3:0] vld_q;
  logic [1:0] flg1_q, flg2_q;
  logic signed [VALUE_WIDTH-1:0] e_q [2];
  logic signed [2*VALUE_WIDTH-1:0] prod_q;
  logic signed [VALUE_WIDTH:0]     sum_q;
  logic                            flg3_q;
  logic signed [WR-1:0]            r_w;
  logic signed [VALUE_WIDTH-1:0]   r_q;
  logic                            sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  assign vld_o = vld_q[3];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [65:0] p_q;
    logic signed [49:0] e_w;

    // emax times fraction, or scaled emax times fraction
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cfg_i.pot_mode) p_q <= $signed({1'b0, cfg_i.emax[l]}) * $signed({1'b0, f_i[l]});
        else                p_q <= $signed(side_i.t[l]) * $signed({1'b0, f_i[l]});
        flg1_q[l] <= side_i.flag[l];
      end
    end

    assign e_w = 50'(p_q >>> 16);

    // clip single drug effect
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (e_w > 50'(VMAX)) begin
          e_q[l]    <= VALUE_WIDTH'(VMAX);
          flg2_q[l] <= 1'b1;
        end else if (e_w < 50'(VMIN)) begin
          e_q[l]    <= VALUE_WIDTH'(VMIN);
          flg2_q[l] <= 1'b1;
        end else begin
          e_q[l]    <= VALUE_WIDTH'(e_w);
          flg2_q[l] <= flg1_q[l];
        end
      end
    end
  end

  // product and sum of the two effects
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= e_q[0] * e_q[1];
      sum_q  <= e_q[0] + e_q[1];
      flg3_q <= |flg2_q;
    end
  end

  // ea + eb - ea * eb, clipped
  assign r_w = WR'(sum_q) - WR'(prod_q >>> 16);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (r_w > WR'(VMAX)) begin
        r_q   <= VALUE_WIDTH'(VMAX);
        sat_q <= 1'b1;
      end else if (r_w < WR'(VMIN)) begin
        r_q   <= VALUE_WIDTH'(VMIN);
        sat_q <= 1'b1;
      end else begin
        r_q   <= VALUE_WIDTH'(r_w);
        sat_q <= flg3_q;
      end
    end
  end

  assign effect_o = 32'(r_q);
  assign sat_o    = sat_q;

endmodule

>>> design/bliss_combined_effect.sv
`timescale 1ns / 1ps

// Combined effect of two drug concentrations by Bliss independence, in
// Q16.16 fixed point. One item is taken per cycle while the skid below is
// empty. Each result passes through the two hill fraction pipelines in
// series (41 stages each: 16 log2 squaring stages and a 17 stage
// restoring divider) plus the interaction and combination stages. The
// output register has a one entry skid behind it: while a result waits
// the pipeline keeps moving until the next result reaches the skid, and
// then holds, input included, until the output is taken. Configuration
// registers are written through the plain write port and must only
// change while no item is in flight.
module bliss_combined_effect import cfe_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  cfe_in_if.sink      in_i,
  cfe_out_if.source   out_o
);

  logic [63:0] emax_q, potency_q, hill_q, gain_q, ipotency_q, ihill_q;
  logic        mode_q;
  cfg_t        cfg;
  logic        en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emax_q     <= PAIR_RESET;
      potency_q  <= PAIR_RESET;
      hill_q     <= PAIR_RESET;
      gain_q     <= PAIR_RESET;
      ipotency_q <= PAIR_RESET;
      ihill_q    <= PAIR_RESET;
      mode_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_EMAX:     emax_q     <= cfg_data_i;
        REG_POTENCY:  potency_q  <= cfg_data_i;
        REG_HILL:     hill_q     <= cfg_data_i;
        REG_GAIN:     gain_q     <= cfg_data_i;
        REG_IPOTENCY: ipotency_q <= cfg_data_i;
        REG_IHILL:    ihill_q    <= cfg_data_i;
        REG_MODE:     mode_q     <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  assign cfg.emax     = emax_q;
  assign cfg.potency  = potency_q;
  assign cfg.hill     = hill_q;
  assign cfg.gain     = gain_q;
  assign cfg.ipotency = ipotency_q;
  assign cfg.ihill    = ihill_q;
  assign cfg.pot_mode = mode_q;

  // interaction fractions, each lane looks at the other drug
  logic             h_vld;
  logic [1:0][16:0] h_f;
  logic [1:0][31:0] h_conc;

  assign in_i.ready = en;

  cfe_hill #(.SIDE_W(64)) u_hill_int (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_i.valid && en),
    .k_i    (cfg.ipotency),
    .c_i    ({in_i.conc_a, in_i.conc_b}),
    .m_i    (cfg.ihill),
    .side_i ({in_i.conc_b, in_i.conc_a}),
    .vld_o  (h_vld),
    .f_o    (h_f),
    .side_o (h_conc)
  );

  logic             fc_vld;
  logic [1:0][31:0] fc_k, fc_c;
  eside_t           fc_side;

  cfe_factor #(.VALUE_WIDTH(VALUE_WIDTH)) u_factor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (h_vld),
    .h_i    (h_f),
    .c_i    (h_conc),
    .cfg_i  (cfg),
    .vld_o  (fc_vld),
    .k_o    (fc_k),
    .c_o    (fc_c),
    .side_o (fc_side)
  );

  // single drug fractions
  logic             s_vld;
  logic [1:0][16:0] s_f;
  eside_t           s_side;

  cfe_hill #(.SIDE_W($bits(eside_t))) u_hill_self (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fc_vld),
    .k_i    (fc_k),
    .c_i    (fc_c),
    .m_i    (cfg.hill),
    .side_i (fc_side),
    .vld_o  (s_vld),
    .f_o    (s_f),
    .side_o (s_side)
  );

  logic        m_vld;
  logic [31:0] m_effect;
  logic        m_sat;

  cfe_merge #(.VALUE_WIDTH(VALUE_WIDTH)) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (s_vld),
    .f_i      (s_f),
    .side_i   (s_side),
    .cfg_i    (cfg),
    .vld_o    (m_vld),
    .effect_o (m_effect),
    .sat_o    (m_sat)
  );

  // output register with one entry skid
  logic        out_vld_q, skid_vld_q;
  logic [31:0] out_eff_q, skid_eff_q;
  logic        out_sat_q, skid_sat_q;

  assign en = !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_o.ready) skid_vld_q <= 1'b0;
    end else if (out_vld_q && !out_o.ready) begin
      skid_vld_q <= m_vld;
    end else begin
      out_vld_q <= m_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_o.ready) begin
        out_eff_q <= skid_eff_q;
        out_sat_q <= skid_sat_q;
      end
    end else if (out_vld_q && !out_o.ready) begin
      skid_eff_q <= m_effect;
      skid_sat_q <= m_sat;
    end else begin
      out_eff_q <= m_effect;
      out_sat_q <= m_sat;
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.effect    = out_eff_q;
  assign out_o.saturated = out_sat_q;

endmodule

>>> design/cfe_checker.sv
`timescale 1ns / 1ps

// port level checks of the stall behavior
module cfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] effect_i,
  input logic        saturated_i
);

  // input stalls only behind a waiting result
  a_stall_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result waiting");

  // stall begins only after a refused result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> $past(out_valid_i && !out_ready_i))
    else $error("input stalled without output back pressure");

  // stall ends only by an output transfer
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_i) |-> $past(out_valid_i && out_ready_i))
    else $error("input released without an output transfer");

  // a refused result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(effect_i) && $stable(saturated_i))
    else $error("result changed while waiting");

endmodule

bind bliss_combined_effect cfe_checker u_cfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .effect_i    (out_o.effect),
  .saturated_i (out_o.saturated)
);
